// File: sv/hpar_pkg.sv
// Package for the pixel to axial hex rounding pipeline.
// Holds fixed-point widths, the Q0.24 constants and the rounding helpers.
// No dependencies.
`default_nettype none

package hpar_pkg;

  localparam int unsigned PIX_W   = 24;
  localparam int unsigned SCALE_W = 24;
  localparam int unsigned HEX_W   = 16;
  localparam int unsigned PROD_W  = 49;
  localparam int unsigned AX_W    = 33;
  localparam int unsigned FX_W    = 58;
  localparam int unsigned INT_W   = 26;
  localparam int unsigned SUM_W   = 27;
  localparam int unsigned ERR_W   = 32;
  localparam int unsigned LAT     = 7;

  localparam logic [23:0] K_INV_SQRT3   = 24'd9686330;
  localparam logic [23:0] K_THIRD       = 24'd5592405;
  localparam logic [23:0] K_TWO_THIRDS  = 24'd11184811;
  localparam logic [SCALE_W-1:0] INV_SCALE_RST = 24'd65536;

  localparam logic signed [SUM_W-1:0] HEX_MAX = 27'sd32767;
  localparam logic signed [SUM_W-1:0] HEX_MIN = -27'sd32768;

  typedef struct packed {
    logic signed [INT_W-1:0] val;
    logic [ERR_W-1:0]        err;
  } rnd_t;

  // divide by 2^16, half away from zero
  function automatic logic signed [AX_W-1:0] rnd16(input logic signed [PROD_W-1:0] v);
    logic [PROD_W-1:0] m;
    logic [PROD_W-1:0] s;
    logic [AX_W-1:0]   q;
    m = v[PROD_W-1] ? PROD_W'(-v) : PROD_W'(v);
    s = (m + PROD_W'(32768)) >> 16;
    q = s[AX_W-1:0];
    return v[PROD_W-1] ? -$signed(q) : $signed(q);
  endfunction

  // round to integer (Q.32 input) half away from zero, with exact error
  function automatic rnd_t rnd32(input logic signed [FX_W-1:0] v);
    logic [FX_W-1:0]  m;
    logic [INT_W-1:0] q;
    rnd_t             o;
    m = v[FX_W-1] ? FX_W'(-v) : FX_W'(v);
    q = m[FX_W-1:32] + INT_W'(m[31]);
    o.val = v[FX_W-1] ? -$signed(q) : $signed(q);
    o.err = m[31] ? ERR_W'(33'h1_0000_0000 - {1'b0, m[31:0]}) : m[31:0];
    return o;
  endfunction

endpackage

`default_nettype wire

// File: sv/hex_pixel_to_axial_round_unit.sv
// Pixel position to pointy-top axial hex cell, seven-stage pipeline.
// Depends on hpar_pkg for constants, widths and rounding helpers.
//
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+---------------------------
//  input    | in_pixel_x, in_pixel_y                  | start high, busy low
//  result   | out_hex_q, out_hex_r, out_saturated     | out_valid, one cycle
//  config   | cfg_wdata                               | cfg_we
//
// One word enters per cycle while busy is low; each result is registered on the outputs
// and is valid while out_valid is high.
// The register stages are the constant multipliers, subtraction, first rounding, scale
// multiplier, z sum, second rounding, and cube correction with clamping.
// Reset clears all stage valid bits and loads inv_scale with one (65536); busy
// stays high while rst_n is low. The receiver cannot stall, so nothing holds.
`default_nettype none

module hex_pixel_to_axial_round_unit (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic signed [hpar_pkg::PIX_W-1:0]    in_pixel_x,
  input  wire logic signed [hpar_pkg::PIX_W-1:0]    in_pixel_y,
  input  wire logic                                 cfg_we,
  input  wire logic [hpar_pkg::SCALE_W-1:0]         cfg_wdata,
  output logic                                      out_valid,
  output logic signed [hpar_pkg::HEX_W-1:0]         out_hex_q,
  output logic signed [hpar_pkg::HEX_W-1:0]         out_hex_r,
  output logic                                      out_saturated
);
  import hpar_pkg::*;

  logic [SCALE_W-1:0] inv_scale_r;
  logic [LAT:1]       vld_r;
  logic [LAT:1]       vld_nxt;

  logic signed [PROD_W-1:0] p1_r, p2_r, p3_r;
  logic signed [PROD_W-1:0] a_r, b_r;
  logic signed [AX_W-1:0]   ra_r, rb_r;
  logic signed [FX_W-1:0]   x4_r, y4_r;
  logic signed [FX_W-1:0]   x5_r, y5_r, z5_r;
  rnd_t                     rx_r, ry_r, rz_r;

  logic signed [SUM_W-1:0]  cq, cr, ez;
  logic signed [HEX_W-1:0]  q_nxt, r_nxt;
  logic                     sat_nxt;

  assign busy = ~rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_scale_r <= INV_SCALE_RST;
    end else if (cfg_we) begin
      inv_scale_r <= cfg_wdata;
    end
  end

  assign vld_nxt = {vld_r[LAT-1:1], start & ~busy};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // advance the datapath every cycle
  always_ff @(posedge clk) begin
    p1_r <= in_pixel_x * $signed({1'b0, K_INV_SQRT3});
    p2_r <= in_pixel_y * $signed({1'b0, K_THIRD});
    p3_r <= in_pixel_y * $signed({1'b0, K_TWO_THIRDS});
    a_r  <= p1_r - p2_r;
    b_r  <= p3_r;
    ra_r <= rnd16(a_r);
    rb_r <= rnd16(b_r);
    x4_r <= ra_r * $signed({1'b0, inv_scale_r});
    y4_r <= rb_r * $signed({1'b0, inv_scale_r});
    x5_r <= x4_r;
    y5_r <= y4_r;
    z5_r <= -x4_r - y4_r;
    rx_r <= rnd32(x5_r);
    ry_r <= rnd32(y5_r);
    rz_r <= rnd32(z5_r);
  end

  always_comb begin
    cq = SUM_W'(rx_r.val);
    cr = SUM_W'(ry_r.val);
    ez = SUM_W'(rz_r.val);
    priority if (rx_r.err > ry_r.err && rx_r.err > rz_r.err) begin
      cq = -SUM_W'(ry_r.val) - SUM_W'(rz_r.val);
    end else if (ry_r.err > rz_r.err) begin
      cr = -SUM_W'(rx_r.val) - SUM_W'(rz_r.val);
    end else begin
      ez = -SUM_W'(rx_r.val) - SUM_W'(ry_r.val);
    end
  end

  always_comb begin
    sat_nxt = 1'b0;
    if (cq > HEX_MAX) begin
      q_nxt   = HEX_MAX[HEX_W-1:0];
      sat_nxt = 1'b1;
    end else if (cq < HEX_MIN) begin
      q_nxt   = HEX_MIN[HEX_W-1:0];
      sat_nxt = 1'b1;
    end else begin
      q_nxt = cq[HEX_W-1:0];
    end
    if (cr > HEX_MAX) begin
      r_nxt   = HEX_MAX[HEX_W-1:0];
      sat_nxt = 1'b1;
    end else if (cr < HEX_MIN) begin
      r_nxt   = HEX_MIN[HEX_W-1:0];
      sat_nxt = 1'b1;
    end else begin
      r_nxt = cr[HEX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    out_hex_q     <= q_nxt;
    out_hex_r     <= r_nxt;
    out_saturated <= sat_nxt;
  end

  assign out_valid = vld_r[LAT];

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result word without an accepted word seven cycles earlier");

  a_cube_sum: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[LAT-1] |-> (cq + cr + ez == '0))
    else $error("corrected cube coordinates do not sum to zero");

  a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturated) |->
      (out_hex_q == 16'sh7fff || out_hex_q == 16'sh8000 ||
       out_hex_r == 16'sh7fff || out_hex_r == 16'sh8000))
    else $error("saturation flag set with neither coordinate at a bound");

endmodule

`default_nettype wire
